### rtl/mpts_pkg.sv
// shared types, constants and pattern functions of the memory self-test sequencer
package mpts_pkg;

    localparam int WORD_BYTES    = 4;
    localparam int WORD_SHIFT    = 2;
    localparam int PATTERN_COUNT = 12;
    localparam int WIDX_W        = 32 - WORD_SHIFT;

    localparam logic [3:0] PH_DATA      = 4'd0;
    localparam logic [3:0] PH_ADDR_LO   = 4'd1;
    localparam logic [3:0] PH_ADDR_HI   = 4'd2;
    localparam logic [3:0] PH_FILL_ZERO = 4'd3;
    localparam logic [3:0] PH_FILL_ONES = 4'd4;
    localparam logic [3:0] PH_FILL_FIVE = 4'd5;
    localparam logic [3:0] PH_FILL_A    = 4'd6;
    localparam logic [3:0] PH_WALK      = 4'd7;
    localparam logic [3:0] PH_INDEX     = 4'd8;
    localparam logic [3:0] PH_INV_INDEX = 4'd9;
    localparam logic [3:0] PH_LAST      = PH_INV_INDEX;

    localparam logic [1:0] SUB_FIRST  = 2'd0;
    localparam logic [1:0] SUB_SECOND = 2'd1;
    localparam logic [1:0] SUB_THIRD  = 2'd2;

    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    localparam logic [31:0] FIRST_MASK    = 32'(WORD_BYTES);
    localparam logic [31:0] GUARD_OFFSET  = 32'd8;
    localparam logic [63:0] GUARD_PATTERN = 64'h0123456789abcdef;

    localparam logic [31:0] FILL_ZERO = 32'h00000000;
    localparam logic [31:0] FILL_ONES = 32'hffffffff;
    localparam logic [31:0] FILL_FIVE = 32'h55555555;
    localparam logic [31:0] FILL_A    = 32'haaaaaaaa;

    typedef enum logic [1:0] {
        CMD_IDLE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_DONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [3:0]        phase;
        logic [1:0]        sub;
        logic [WIDX_W-1:0] widx;
        logic [31:0]       fmask;
        logic [31:0]       capt;
        logic              running;
        logic              finished;
        logic              fail;
        logic [31:0]       fail_addr;
        logic [63:0]       fail_exp;
        logic [63:0]       fail_obs;
    } t_state;

    typedef struct packed {
        t_cmd        cmd;
        logic        wide;
        logic [31:0] addr;
        logic [63:0] wval;
        logic [3:0]  phase;
        logic        failed;
        logic [31:0] fail_addr;
        logic [63:0] fail_exp;
        logic [63:0] fail_obs;
    } t_result;

    typedef struct packed {
        logic [31:0] valid_lo;
        logic [31:0] valid_hi;
        logic [31:0] addr_hi;
    } t_scan;

    function automatic logic [63:0] data_pattern(input logic [3:0] idx);
        logic [63:0] p;
        case (idx)
            4'd0:    p = 64'haaaaaaaaaaaaaaaa;
            4'd1:    p = 64'hcccccccccccccccc;
            4'd2:    p = 64'hf0f0f0f0f0f0f0f0;
            4'd3:    p = 64'hff00ff00ff00ff00;
            4'd4:    p = 64'hffff0000ffff0000;
            4'd5:    p = 64'hffffffff00000000;
            4'd6:    p = 64'h00000000ffffffff;
            4'd7:    p = 64'h0000ffff0000ffff;
            4'd8:    p = 64'h00ff00ff00ff00ff;
            4'd9:    p = 64'h0f0f0f0f0f0f0f0f;
            4'd10:   p = 64'h3333333333333333;
            4'd11:   p = 64'h5555555555555555;
            default: p = 64'h0;
        endcase
        return p;
    endfunction

    function automatic logic [31:0] fill_value(input logic [3:0] ph, input logic [31:0] i);
        logic [31:0] v;
        case (ph)
            PH_FILL_ZERO: v = FILL_ZERO;
            PH_FILL_ONES: v = FILL_ONES;
            PH_FILL_FIVE: v = FILL_FIVE;
            PH_FILL_A:    v = FILL_A;
            PH_WALK:      v = 32'd1 << i[4:0];
            PH_INDEX:     v = i;
            default:      v = ~i;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] lowest_bit(input logic [31:0] x);
        return x & (~x + 32'd1);
    endfunction

    function automatic logic [31:0] at_or_above(input logic [31:0] m);
        return (m == 32'd0) ? 32'd0 : ~(m - 32'd1);
    endfunction

endpackage

### rtl/mpts_addr_scan.sv
// address-line target check: which flipped-bit targets fall inside the region
module mpts_addr_scan (
    input  logic [31:0]    i_base,
    input  logic [31:0]    i_size,
    output mpts_pkg::t_scan o_scan
);
    import mpts_pkg::*;

    always_comb begin
        logic [32:0] region_end;
        logic [31:0] addr_hi;
        logic [31:0] tgt_lo;
        logic [31:0] tgt_hi;
        region_end = {1'b0, i_base} + {1'b0, i_size};
        addr_hi    = i_base + i_size - GUARD_OFFSET;
        o_scan.valid_lo = '0;
        o_scan.valid_hi = '0;
        o_scan.addr_hi  = addr_hi;
        tgt_lo = '0;
        tgt_hi = '0;
        for (int k = WORD_SHIFT; k < 32; k++) begin
            tgt_lo = i_base ^ (32'd1 << k);
            tgt_hi = addr_hi ^ (32'd1 << k);
            o_scan.valid_lo[k] = (tgt_lo >= i_base) && ({1'b0, tgt_lo} < region_end);
            o_scan.valid_hi[k] = (tgt_hi >= i_base) && ({1'b0, tgt_hi} < region_end);
        end
    end

endmodule

### rtl/mpts_step.sv
// next sequencer state from the current state and one input beat
module mpts_step (
    input  mpts_pkg::t_state i_st,
    input  logic             i_opcode,
    input  logic [63:0]      i_read_data,
    input  logic [31:0]      i_base,
    input  logic [31:0]      i_size,
    input  mpts_pkg::t_scan  i_scan,
    output mpts_pkg::t_state o_st
);
    import mpts_pkg::*;

    always_comb begin
        t_state      n;
        logic [WIDX_W-1:0] wc;
        logic [31:0] first_lo;
        logic [31:0] first_hi;
        logic [31:0] vcur;
        logic [31:0] mnext;
        logic [31:0] srch;
        logic [31:0] taddr;
        logic [31:0] target;
        logic [63:0] pat;
        logic [31:0] fexp;
        logic [31:0] rd_lo;
        logic        fin;
        logic        to_lo;
        logic        to_hi;
        logic        to_fill;

        n        = i_st;
        wc       = i_size[31:WORD_SHIFT];
        first_lo = lowest_bit(i_scan.valid_lo);
        first_hi = lowest_bit(i_scan.valid_hi);
        vcur     = (i_st.phase == PH_ADDR_LO) ? i_scan.valid_lo : i_scan.valid_hi;
        taddr    = (i_st.phase == PH_ADDR_LO) ? i_base : i_scan.addr_hi;
        target   = taddr ^ i_st.fmask;
        mnext    = (i_st.sub == SUB_THIRD) ? (i_st.fmask << 1) : i_st.fmask;
        srch     = lowest_bit(vcur & at_or_above(mnext));
        pat      = data_pattern(i_st.widx[3:0]);
        fexp     = fill_value(i_st.phase, {{(32-WIDX_W){1'b0}}, i_st.widx});
        rd_lo    = i_read_data[31:0];
        fin      = 1'b0;
        to_lo    = 1'b0;
        to_hi    = 1'b0;
        to_fill  = 1'b0;

        if (!i_opcode) begin
            n         = '0;
            n.fmask   = FIRST_MASK;
            n.running = 1'b1;
        end else if (i_st.running) begin
            case (i_st.phase)
                PH_DATA: begin
                    if (i_st.sub == SUB_THIRD && i_read_data != pat && !i_st.fail) begin
                        n.fail      = 1'b1;
                        n.fail_addr = i_base;
                        n.fail_exp  = pat;
                        n.fail_obs  = i_read_data;
                    end
                    if (i_st.sub == SUB_THIRD) begin
                        n.sub  = SUB_FIRST;
                        n.widx = i_st.widx + 1'b1;
                    end else begin
                        n.sub = i_st.sub + 1'b1;
                    end
                    if (n.widx >= WIDX_W'(PATTERN_COUNT)) begin
                        if (n.fail) begin
                            fin = 1'b1;
                        end else if (first_lo != 32'd0) begin
                            to_lo = 1'b1;
                        end else if (first_hi != 32'd0) begin
                            to_hi = 1'b1;
                        end else begin
                            to_fill = 1'b1;
                        end
                    end
                end
                PH_ADDR_LO, PH_ADDR_HI: begin
                    if (i_st.sub == SUB_FIRST) begin
                        n.capt = rd_lo;
                    end else if (i_st.sub == SUB_THIRD && rd_lo == ~i_st.capt
                                 && !i_st.fail) begin
                        n.fail      = 1'b1;
                        n.fail_addr = target;
                        n.fail_exp  = {32'd0, i_st.capt};
                        n.fail_obs  = {32'd0, rd_lo};
                    end
                    n.sub   = (i_st.sub == SUB_THIRD) ? SUB_FIRST : i_st.sub + 1'b1;
                    n.fmask = srch;
                    if (srch == 32'd0) begin
                        if (n.fail) begin
                            fin = 1'b1;
                        end else if (i_st.phase == PH_ADDR_LO && first_hi != 32'd0) begin
                            to_hi = 1'b1;
                        end else begin
                            to_fill = 1'b1;
                        end
                    end
                end
                default: begin
                    if (i_st.sub == SUB_SECOND && rd_lo != fexp) begin
                        if (!i_st.fail) begin
                            n.fail      = 1'b1;
                            n.fail_addr = i_base + {i_st.widx, {WORD_SHIFT{1'b0}}};
                            n.fail_exp  = {32'd0, fexp};
                            n.fail_obs  = {32'd0, rd_lo};
                        end
                        fin = 1'b1;
                    end else begin
                        n.widx = i_st.widx + 1'b1;
                        if (n.widx >= wc) begin
                            if (wc == '0) begin
                                // region shrank below one word: remaining fill passes skipped
                                n.phase = PH_LAST;
                                n.sub   = SUB_SECOND;
                                n.widx  = '0;
                                fin     = 1'b1;
                            end else if (i_st.sub == SUB_FIRST) begin
                                n.sub  = SUB_SECOND;
                                n.widx = '0;
                            end else if (i_st.phase >= PH_LAST) begin
                                fin = 1'b1;
                            end else begin
                                n.phase = i_st.phase + 1'b1;
                                n.sub   = SUB_FIRST;
                                n.widx  = '0;
                                n.fmask = FIRST_MASK;
                            end
                        end
                    end
                end
            endcase
        end

        if (to_lo) begin
            n.phase = PH_ADDR_LO;
            n.sub   = SUB_FIRST;
            n.widx  = '0;
            n.fmask = first_lo;
        end
        if (to_hi) begin
            n.phase = PH_ADDR_HI;
            n.sub   = SUB_FIRST;
            n.widx  = '0;
            n.fmask = first_hi;
        end
        if (to_fill) begin
            n.widx  = '0;
            n.fmask = FIRST_MASK;
            if (wc == '0) begin
                // region too small for a word: every fill pass is skipped
                n.phase = PH_LAST;
                n.sub   = SUB_SECOND;
                fin     = 1'b1;
            end else begin
                n.phase = PH_FILL_ZERO;
                n.sub   = SUB_FIRST;
            end
        end
        if (fin) begin
            n.running  = 1'b0;
            n.finished = 1'b1;
        end
        o_st = n;
    end

endmodule

### rtl/mpts_emit.sv
// memory command and status fields for a sequencer state
module mpts_emit (
    input  mpts_pkg::t_state  i_st,
    input  logic [31:0]       i_base,
    input  logic [31:0]       i_addr_hi,
    output mpts_pkg::t_result o_res
);
    import mpts_pkg::*;

    always_comb begin
        logic [31:0] taddr;
        logic [31:0] widx32;
        taddr  = (i_st.phase == PH_ADDR_LO) ? i_base : i_addr_hi;
        widx32 = {{(32-WIDX_W){1'b0}}, i_st.widx};

        o_res.cmd       = CMD_IDLE;
        o_res.wide      = 1'b0;
        o_res.addr      = 32'd0;
        o_res.wval      = 64'd0;
        o_res.phase     = i_st.phase;
        o_res.failed    = i_st.fail;
        o_res.fail_addr = i_st.fail_addr;
        o_res.fail_exp  = i_st.fail_exp;
        o_res.fail_obs  = i_st.fail_obs;

        if (i_st.running) begin
            case (i_st.phase)
                PH_DATA: begin
                    o_res.wide = 1'b1;
                    case (i_st.sub)
                        SUB_FIRST: begin
                            o_res.cmd  = CMD_WRITE;
                            o_res.addr = i_base;
                            o_res.wval = data_pattern(i_st.widx[3:0]);
                        end
                        SUB_SECOND: begin
                            o_res.cmd  = CMD_WRITE;
                            o_res.addr = i_base + GUARD_OFFSET;
                            o_res.wval = GUARD_PATTERN;
                        end
                        default: begin
                            o_res.cmd  = CMD_READ;
                            o_res.addr = i_base;
                        end
                    endcase
                end
                PH_ADDR_LO, PH_ADDR_HI: begin
                    if (i_st.sub == SUB_SECOND) begin
                        o_res.cmd  = CMD_WRITE;
                        o_res.addr = taddr;
                        o_res.wval = {32'd0, ~i_st.capt};
                    end else begin
                        o_res.cmd  = CMD_READ;
                        o_res.addr = taddr ^ i_st.fmask;
                    end
                end
                default: begin
                    o_res.addr = i_base + {i_st.widx, {WORD_SHIFT{1'b0}}};
                    if (i_st.sub == SUB_FIRST) begin
                        o_res.cmd  = CMD_WRITE;
                        o_res.wval = {32'd0, fill_value(i_st.phase, widx32)};
                    end else begin
                        o_res.cmd = CMD_READ;
                    end
                end
            endcase
        end else if (i_st.finished) begin
            o_res.cmd = CMD_DONE;
        end
    end

endmodule

### rtl/memory_post_test_sequencer.sv
// top level of the memory self-test sequencer: registers, handshakes, config port
//
//  channel   direction  handshake                   payload
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//  step      in         i_valid / o_ready           i_opcode, i_read_data
//  result    out        o_valid / i_ready           o_command ... o_observed_value
//
// one result beat per step beat, one step beat per cycle when the result side keeps up
// the whole step (address-line target search, compare, next command) is combinational
// from the sequencer state register into the result register
// a held result stalls the step channel only while the result register stays full
// synchronous active-low reset: base 0, size 16, sequencer idle, failure record clear
module memory_post_test_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [63:0] i_read_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_command,
    output logic        o_wide_access,
    output logic [31:0] o_mem_address,
    output logic [63:0] o_write_value,
    output logic [3:0]  o_phase,
    output logic        o_failed,
    output logic [31:0] o_fail_address,
    output logic [63:0] o_expected_value,
    output logic [63:0] o_observed_value
);
    import mpts_pkg::*;

    logic [31:0] r_base;
    logic [31:0] r_size;
    t_state      r_st;
    t_state      n_st;
    t_result     r_res;
    t_result     n_res;
    logic        r_valid;
    t_scan       s_scan;
    t_state      s_reset_st;
    logic        s_accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_valid || i_ready;
    assign s_accept    = i_valid && o_ready;

    always_comb begin
        s_reset_st       = '0;
        s_reset_st.fmask = FIRST_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 32'd0;
            r_size <= 32'd16;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASE: r_base <= i_cfg_data;
                CFG_SIZE: r_size <= i_cfg_data;
                default:  r_base <= r_base;
            endcase
        end
    end

    mpts_addr_scan u_scan (
        .i_base (r_base),
        .i_size (r_size),
        .o_scan (s_scan)
    );

    mpts_step u_step (
        .i_st        (r_st),
        .i_opcode    (i_opcode),
        .i_read_data (i_read_data),
        .i_base      (r_base),
        .i_size      (r_size),
        .i_scan      (s_scan),
        .o_st        (n_st)
    );

    mpts_emit u_emit (
        .i_st      (n_st),
        .i_base    (r_base),
        .i_addr_hi (s_scan.addr_hi),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= s_reset_st;
            r_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_st    <= n_st;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_res <= n_res;
        end
    end

    assign o_valid          = r_valid;
    assign o_command        = r_res.cmd;
    assign o_wide_access    = r_res.wide;
    assign o_mem_address    = r_res.addr;
    assign o_write_value    = r_res.wval;
    assign o_phase          = r_res.phase;
    assign o_failed         = r_res.failed;
    assign o_fail_address   = r_res.fail_addr;
    assign o_expected_value = r_res.fail_exp;
    assign o_observed_value = r_res.fail_obs;

    // a failure stays recorded until a start beat
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.fail && !(s_accept && !i_opcode) |=> r_st.fail)
        else $error("failure flag dropped without a start");

    a_run_or_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_st.running && r_st.finished))
        else $error("sequencer both running and finished");

    a_mask_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.running && (r_st.phase == PH_ADDR_LO || r_st.phase == PH_ADDR_HI)
        |-> $onehot(r_st.fmask))
        else $error("address-line flip mask not one-hot while running");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase <= PH_LAST)
        else $error("phase beyond last fill pass");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_res))
        else $error("pending result beat changed before it was taken");

endmodule
